### rtl/core/q2rm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the quaternion to rotation matrix core.
// No dependencies; imported by quaternion_to_rotation_matrix_core.
package q2rm_pkg;

    localparam int CompW   = 16;            // input component width, Q4.12
    localparam int EntryW  = 16;            // output entry width, Q1.14
    localparam int NumProd = 10;            // distinct component products
    localparam int NumLane = 9;             // matrix entries computed
    localparam int QuoW    = 16;            // quotient bits, one per divide stage
    localparam int DivW    = 33;            // squared norm width (max 2^32)
    localparam int NumW    = 34;            // signed numerator width
    localparam int PreStg  = 4;             // stages before the divider
    localparam int NumStg  = PreStg + QuoW + 1;
    localparam logic [EntryW-1:0] OneQ14 = 16'sd16384;

    // Product slots.
    localparam int PXX = 0;
    localparam int PYY = 1;
    localparam int PZZ = 2;
    localparam int PWW = 3;
    localparam int PXY = 4;
    localparam int PZW = 5;
    localparam int PXZ = 6;
    localparam int PYW = 7;
    localparam int PYZ = 8;
    localparam int PXW = 9;

    typedef logic signed [CompW-1:0]   t_comp;
    typedef logic signed [2*CompW-1:0] t_prod;
    typedef logic signed [NumW-1:0]    t_num;
    typedef logic [DivW-1:0]           t_mag;
    typedef logic [QuoW-1:0]           t_quo;
    typedef logic signed [EntryW-1:0]  t_entry;

endpackage

### rtl/core/quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix, fixed point, fully pipelined.
// Depends on q2rm_pkg for widths, product slots and types.
//
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_comp_x, i_comp_y, i_comp_z, i_comp_w (Q4.12)
// output  | out       | o_valid / i_stall  | o_entry_0..o_entry_10 (Q1.14), o_zero_length
//
// One quaternion can be taken every cycle while o_stall is low; each result passes
// through the register stages in order on its way to the output. There are 21 register
// stages: four front stages (the first loads at the input transfer itself), sixteen
// divider stages that resolve one quotient bit each, and the output register.
// Reset clears only the valid bits. A stall holds only the stages that are full up
// to the output, so empty stages keep filling behind it.
module quaternion_to_rotation_matrix_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  q2rm_pkg::t_comp        i_comp_x,
    input  q2rm_pkg::t_comp        i_comp_y,
    input  q2rm_pkg::t_comp        i_comp_z,
    input  q2rm_pkg::t_comp        i_comp_w,
    output logic                   o_valid,
    input  logic                   i_stall,
    output q2rm_pkg::t_entry       o_entry_0,
    output q2rm_pkg::t_entry       o_entry_1,
    output q2rm_pkg::t_entry       o_entry_2,
    output q2rm_pkg::t_entry       o_entry_4,
    output q2rm_pkg::t_entry       o_entry_5,
    output q2rm_pkg::t_entry       o_entry_6,
    output q2rm_pkg::t_entry       o_entry_8,
    output q2rm_pkg::t_entry       o_entry_9,
    output q2rm_pkg::t_entry       o_entry_10,
    output logic                   o_zero_length
);
    import q2rm_pkg::*;

    // Per-stage valid bits and load enables. A stage loads when it is empty or when
    // the stage after it is loading too, so bubbles collapse under a stall.
    logic [NumStg-1:0] r_v;
    logic [NumStg-1:0] w_en;

    always_comb begin
        w_en[NumStg-1] = !r_v[NumStg-1] || !i_stall;
        for (int s = NumStg - 2; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NumStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NumStg; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // Stage 0: capture the components.
    t_comp r_x, r_y, r_z, r_w;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x <= i_comp_x;
            r_y <= i_comp_y;
            r_z <= i_comp_z;
            r_w <= i_comp_w;
        end
    end

    // Stage 1: the ten 16x16 products, each in its own multiplier.
    t_prod r_p [NumProd];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p[PXX] <= r_x * r_x;
            r_p[PYY] <= r_y * r_y;
            r_p[PZZ] <= r_z * r_z;
            r_p[PWW] <= r_w * r_w;
            r_p[PXY] <= r_x * r_y;
            r_p[PZW] <= r_z * r_w;
            r_p[PXZ] <= r_x * r_z;
            r_p[PYW] <= r_y * r_w;
            r_p[PYZ] <= r_y * r_z;
            r_p[PXW] <= r_x * r_w;
        end
    end

    // Stage 2: squared norm and the nine numerators. Normalizing and then squaring
    // is the same as dividing each product form by the squared norm.
    t_num e [NumProd];
    t_num n_norm;
    t_num n_num [NumLane];
    t_num r_norm;
    t_num r_num [NumLane];

    always_comb begin
        for (int i = 0; i < NumProd; i++) begin
            e[i] = NumW'(r_p[i]);
        end
        n_norm     = e[PXX] + e[PYY] + e[PZZ] + e[PWW];
        n_num[0]   = n_norm - (e[PYY] <<< 1) - (e[PZZ] <<< 1);
        n_num[1]   = (e[PXY] + e[PZW]) <<< 1;
        n_num[2]   = (e[PXZ] - e[PYW]) <<< 1;
        n_num[3]   = (e[PXY] - e[PZW]) <<< 1;
        n_num[4]   = n_norm - (e[PXX] <<< 1) - (e[PZZ] <<< 1);
        n_num[5]   = (e[PYZ] + e[PXW]) <<< 1;
        n_num[6]   = (e[PXZ] + e[PYW]) <<< 1;
        n_num[7]   = (e[PYZ] - e[PXW]) <<< 1;
        n_num[8]   = n_norm - (e[PXX] <<< 1) - (e[PYY] <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_norm <= n_norm;
            r_num  <= n_num;
        end
    end

    // Stage 3: magnitudes and signs. A zero norm is replaced by one so the divider
    // sees a legal divisor; the result is overridden at the output anyway.
    t_mag r_dv0;
    t_mag r_mag [NumLane];
    logic [NumLane-1:0] r_sg0;
    logic r_zf0;
    logic w_zero;

    assign w_zero = (r_norm == '0);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_dv0 <= w_zero ? DivW'(1) : r_norm[DivW-1:0];
            r_zf0 <= w_zero;
            for (int l = 0; l < NumLane; l++) begin
                r_sg0[l]  <= r_num[l][NumW-1];
                r_mag[l]  <= r_num[l][NumW-1] ? DivW'(-r_num[l]) : r_num[l][DivW-1:0];
            end
        end
    end

    // Divide stages: restoring division, one quotient bit per stage, giving
    // floor(mag * 2^15 / norm). The remainder always stays below the divisor.
    t_mag r_rem [QuoW][NumLane];
    t_quo r_quo [QuoW][NumLane];
    t_mag r_dv  [QuoW];
    logic [NumLane-1:0] r_sg [QuoW];
    logic r_zf [QuoW];

    t_mag n_rem [QuoW][NumLane];
    t_quo n_quo [QuoW][NumLane];
    logic [DivW:0] w_rin;
    logic [DivW:0] w_dif;
    t_mag w_d;

    always_comb begin
        for (int k = 0; k < QuoW; k++) begin
            w_d = (k == 0) ? r_dv0 : r_dv[k-1];
            for (int l = 0; l < NumLane; l++) begin
                if (k == 0) begin
                    w_rin = {1'b0, r_mag[l]};
                end else begin
                    w_rin = {r_rem[k-1][l], 1'b0};
                end
                w_dif = w_rin - {1'b0, w_d};
                if (w_rin >= {1'b0, w_d}) begin
                    n_rem[k][l] = w_dif[DivW-1:0];
                end else begin
                    n_rem[k][l] = w_rin[DivW-1:0];
                end
                if (k == 0) begin
                    n_quo[k][l] = QuoW'(w_rin >= {1'b0, w_d});
                end else begin
                    n_quo[k][l] = {r_quo[k-1][l][QuoW-2:0], (w_rin >= {1'b0, w_d})};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QuoW; k++) begin
            if (w_en[PreStg+k]) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dv[k]  <= (k == 0) ? r_dv0 : r_dv[k-1];
                r_sg[k]  <= (k == 0) ? r_sg0 : r_sg[k-1];
                r_zf[k]  <= (k == 0) ? r_zf0 : r_zf[k-1];
            end
        end
    end

    // Output stage: round half away from zero by (Q + 1) >> 1, clamp to one,
    // restore the sign, and force identity on a zero-length input.
    t_entry n_out [NumLane];
    t_entry r_out [NumLane];
    logic   r_zl;
    logic [QuoW:0] w_q;
    t_entry w_mq;

    always_comb begin
        for (int l = 0; l < NumLane; l++) begin
            w_q  = ({1'b0, r_quo[QuoW-1][l]} + (QuoW+1)'(1)) >> 1;
            w_mq = (w_q > (QuoW+1)'(OneQ14)) ? OneQ14 : EntryW'(w_q);
            if (r_zf[QuoW-1]) begin
                n_out[l] = (l == 0 || l == 4 || l == 8) ? OneQ14 : '0;
            end else begin
                n_out[l] = r_sg[QuoW-1][l] ? -w_mq : w_mq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NumStg-1]) begin
            r_out <= n_out;
            r_zl  <= r_zf[QuoW-1];
        end
    end

    assign o_entry_0     = r_out[0];
    assign o_entry_1     = r_out[1];
    assign o_entry_2     = r_out[2];
    assign o_entry_4     = r_out[3];
    assign o_entry_5     = r_out[4];
    assign o_entry_6     = r_out[5];
    assign o_entry_8     = r_out[6];
    assign o_entry_9     = r_out[7];
    assign o_entry_10    = r_out[8];
    assign o_zero_length = r_zl;

    // The input is held back only when every stage up to a stalled output is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_v[0]))
        else $error("input stalled while the pipeline has room");

    // The divider never sees a zero divisor.
    a_dv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[PreStg] |-> (r_dv[0] != '0))
        else $error("zero divisor entered the divider");

    // A zero-length result is the identity matrix; entries 0, 1, 9 and 10 are checked.
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |-> (o_entry_0 == OneQ14 && o_entry_1 == '0
            && o_entry_9 == '0 && o_entry_10 == OneQ14))
        else $error("zero-length result is not the identity");

    // Every entry lies in [-1, +1]; this assertion checks entry 1.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_entry_1) <= $signed(OneQ14)
            && $signed(o_entry_1) >= -$signed(OneQ14)))
        else $error("entry out of range");

endmodule
